### rtl/tops_pkg.sv
`default_nettype none

package tops_pkg;

	// opcodes carried in the slave tuser
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_MANUAL = 2'd2;

	localparam int NUM_OUTPUTS  = 2;
	localparam int NUM_PATTERNS = 4;
	localparam int MAX_STEPS    = 32;
	localparam int ROM_PATTERNS = 4;
	localparam int ROM_STEPS    = 26;

	// a pattern number is usable only below both limits
	localparam int PAT_LIMIT = (NUM_PATTERNS < ROM_PATTERNS) ? NUM_PATTERNS : ROM_PATTERNS;
	localparam int PAT_AW    = (ROM_PATTERNS > 1) ? $clog2(ROM_PATTERNS) : 1;

	localparam int LV_W   = 2;
	localparam int PAT_W  = 3;
	localparam int STEP_W = 5;
	localparam int LEN_W  = 7;

	localparam logic [PAT_W-1:0] IDLE_CODE = PAT_W'(NUM_PATTERNS);

	typedef struct packed {
		logic [15:0]     at_ms;
		logic [LV_W-1:0] lv;
	} step_t;

endpackage

`default_nettype wire

### rtl/timed_output_pattern_sequencer.sv
// channel  | dir | signals                          | contents
// s        | in  | s_tvalid s_tready s_tdata s_tuser | command or tick beat
// m        | out | m_tvalid m_tready m_tdata         | levels and sequencer status
//
// one beat per cycle while s_tready is high; each result is registered on its beat
// the step table is a synchronous rom addressed by the next state, so the entry for
// the following beat is always registered in time; the loop is state -> rom -> state
// reset (arst_n low) gives no pattern, step 0, start time 0, both outputs off
// a two-deep output buffer keeps s_tready high for one beat while m_tready is low

`default_nettype none

module timed_output_pattern_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // target_index[2:0], level[3], now_ms[35:4], zero fill
	input  wire  [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // output_levels[1:0], active_pattern[4:2], next_step[9:5]
);

	localparam tops_pkg::step_t ROM [tops_pkg::ROM_PATTERNS][tops_pkg::ROM_STEPS] = '{
		'{ '{16'd0,2'd1}, '{16'd100,2'd0}, '{16'd500,2'd2}, '{16'd600,2'd0},
		   '{16'd1000,2'd1}, '{16'd1100,2'd0}, '{16'd1300,2'd2}, '{16'd1400,2'd0},
		   '{16'd2000,2'd3}, '{16'd2500,2'd0}, '{16'd3000,2'd3}, '{16'd3500,2'd0},
		   '{16'd4500,2'd3}, '{16'd5000,2'd3}, '{16'd5500,2'd3}, '{16'd6000,2'd3},
		   '{16'd6500,2'd3}, '{16'd8000,2'd3}, '{16'd0,2'd0}, '{16'd0,2'd0},
		   '{16'd0,2'd0}, '{16'd0,2'd0}, '{16'd0,2'd0}, '{16'd0,2'd0},
		   '{16'd0,2'd0}, '{16'd0,2'd0} },
		'{ '{16'd0,2'd1}, '{16'd100,2'd2}, '{16'd200,2'd1}, '{16'd300,2'd2},
		   '{16'd400,2'd1}, '{16'd500,2'd2}, '{16'd600,2'd1}, '{16'd700,2'd2},
		   '{16'd800,2'd1}, '{16'd900,2'd2}, '{16'd1000,2'd1}, '{16'd1100,2'd2},
		   '{16'd1200,2'd1}, '{16'd1300,2'd2}, '{16'd1400,2'd1}, '{16'd1500,2'd2},
		   '{16'd1600,2'd1}, '{16'd1700,2'd2}, '{16'd1800,2'd1}, '{16'd1900,2'd2},
		   '{16'd2000,2'd1}, '{16'd2100,2'd2}, '{16'd2200,2'd1}, '{16'd2300,2'd2},
		   '{16'd2400,2'd1}, '{16'd2500,2'd0} },
		'{ '{16'd0,2'd1}, '{16'd100,2'd2}, '{16'd200,2'd0}, '{16'd300,2'd2},
		   '{16'd400,2'd1}, '{16'd500,2'd0}, '{16'd600,2'd1}, '{16'd700,2'd2},
		   '{16'd800,2'd0}, '{16'd900,2'd2}, '{16'd1000,2'd1}, '{16'd1100,2'd0},
		   '{16'd1200,2'd3}, '{16'd1500,2'd0}, '{16'd2000,2'd3}, '{16'd2500,2'd0},
		   '{16'd3000,2'd3}, '{16'd3500,2'd0}, '{16'd0,2'd0}, '{16'd0,2'd0},
		   '{16'd0,2'd0}, '{16'd0,2'd0}, '{16'd0,2'd0}, '{16'd0,2'd0},
		   '{16'd0,2'd0}, '{16'd0,2'd0} },
		'{ '{16'd0,2'd1}, '{16'd100,2'd0}, '{16'd200,2'd1}, '{16'd300,2'd0},
		   '{16'd400,2'd1}, '{16'd500,2'd0}, '{16'd600,2'd1}, '{16'd700,2'd2},
		   '{16'd800,2'd0}, '{16'd900,2'd2}, '{16'd1000,2'd0}, '{16'd1100,2'd2},
		   '{16'd1200,2'd0}, '{16'd1300,2'd2}, '{16'd1400,2'd0}, '{16'd1500,2'd3},
		   '{16'd2000,2'd3}, '{16'd2200,2'd0}, '{16'd2500,2'd3}, '{16'd2700,2'd3},
		   '{16'd2900,2'd0}, '{16'd3200,2'd3}, '{16'd3400,2'd3}, '{16'd3600,2'd0},
		   '{16'd0,2'd0}, '{16'd0,2'd0} }
	};

	localparam logic [tops_pkg::LEN_W-1:0] ROM_LEN [tops_pkg::ROM_PATTERNS] = '{
		7'd18, 7'd26, 7'd18, 7'd24
	};

	// input fields
	logic [1:0]  op;
	logic [2:0]  target_index;
	logic        level;
	logic [31:0] now_ms;
	logic        s_fire;

	assign op           = s_tuser;
	assign target_index = s_tdata[2:0];
	assign level        = s_tdata[3];
	assign now_ms       = s_tdata[35:4];

	// sequencer state
	logic [tops_pkg::PAT_W-1:0]  pat_q,  pat_d;
	logic [tops_pkg::STEP_W-1:0] step_q, step_d;
	logic [31:0]                 start_q, start_d;
	logic [tops_pkg::LV_W-1:0]   drive_q, drive_d;
	tops_pkg::step_t             rom_q;

	logic                        pat_run;
	logic [tops_pkg::LEN_W-1:0]  pat_len;
	logic                        past_end;
	logic [31:0]                 elapsed;
	logic                        tgt_pat_ok;
	logic                        tgt_out_ok;
	logic [tops_pkg::PAT_AW-1:0] rom_pat;
	logic [tops_pkg::STEP_W-1:0] rom_step;

	assign pat_run    = {1'b0, pat_q} < 4'(tops_pkg::PAT_LIMIT);
	assign tgt_pat_ok = {1'b0, target_index} < 4'(tops_pkg::PAT_LIMIT);
	assign tgt_out_ok = {1'b0, target_index} < 4'(tops_pkg::NUM_OUTPUTS);

	always_comb begin
		pat_len = ROM_LEN[pat_q[tops_pkg::PAT_AW-1:0]];
		if (pat_len > tops_pkg::LEN_W'(tops_pkg::MAX_STEPS)) begin
			pat_len = tops_pkg::LEN_W'(tops_pkg::MAX_STEPS);
		end
	end

	assign past_end = ({2'b00, step_q} >= pat_len) ||
	                  ({2'b00, step_q} >= tops_pkg::LEN_W'(tops_pkg::ROM_STEPS));
	assign elapsed  = now_ms - start_q;

	always_comb begin
		pat_d   = pat_q;
		step_d  = step_q;
		start_d = start_q;
		drive_d = drive_q;
		if (s_fire) begin
			case (op)
				tops_pkg::OP_TICK: begin
					if (pat_run) begin
						if (past_end) begin
							pat_d   = tops_pkg::IDLE_CODE;
							drive_d = '0;
						end else if (elapsed >= {16'd0, rom_q.at_ms}) begin
							drive_d = rom_q.lv;
							step_d  = step_q + 1'b1;
						end
					end
				end
				tops_pkg::OP_START: begin
					if (tgt_pat_ok && (pat_q != target_index)) begin
						pat_d   = target_index;
						start_d = now_ms;
						drive_d = ROM[target_index[tops_pkg::PAT_AW-1:0]][0].lv;
						step_d  = tops_pkg::STEP_W'(1);
					end
				end
				tops_pkg::OP_MANUAL: begin
					if ((!pat_run || level) && tgt_out_ok) begin
						pat_d = tops_pkg::IDLE_CODE;
						for (int i = 0; i < tops_pkg::NUM_OUTPUTS; i++) begin
							if (target_index == 3'(i)) begin
								drive_d[i] = level;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// rom addressed by the next state so the entry is ready for the next beat
	assign rom_pat  = pat_d[tops_pkg::PAT_AW-1:0];
	assign rom_step = ({2'b00, step_d} < tops_pkg::LEN_W'(tops_pkg::ROM_STEPS)) ? step_d : '0;

	always_ff @(posedge clk) begin
		rom_q <= ROM[rom_pat][rom_step];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= tops_pkg::IDLE_CODE;
			step_q  <= '0;
			start_q <= '0;
			drive_q <= '0;
		end else begin
			pat_q   <= pat_d;
			step_q  <= step_d;
			start_q <= start_d;
			drive_q <= drive_d;
		end
	end

	// output register plus one skid entry
	logic        out_vld_q, skid_vld_q;
	logic [15:0] out_data_q, skid_data_q;
	logic [15:0] res_data;
	logic        m_fire;

	assign res_data = {6'd0, step_d, pat_d, drive_d};
	assign s_tready = !skid_vld_q;
	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = out_vld_q && m_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (m_fire || !out_vld_q) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= s_fire;
				end
			end else if (s_fire) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_fire || !out_vld_q) begin
			out_data_q <= skid_vld_q ? skid_data_q : res_data;
		end else if (s_fire) begin
			skid_data_q <= res_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held while output register empty");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{2'b00, step_q} <= tops_pkg::LEN_W'(tops_pkg::ROM_STEPS))
		else $error("step index ran past the table");

	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && op == tops_pkg::OP_START && tgt_pat_ok && pat_q != target_index)
		|=> (step_q == tops_pkg::STEP_W'(1) && pat_q == $past(target_index)))
		else $error("start did not load pattern and step");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && op == tops_pkg::OP_TICK && pat_run && past_end)
		|=> (drive_q == '0 && pat_q == tops_pkg::IDLE_CODE))
		else $error("end of pattern left outputs driven");

	a_result_order: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && !out_vld_q) |=> (out_vld_q && out_data_q == $past(res_data)))
		else $error("result lost on empty output register");

endmodule

`default_nettype wire
